FILE: rtl/core/radial_lens_vertex_deform_macros.svh
// ----------------------------------------------------------------------------
// Radial lens vertex deform assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef RADIAL_LENS_VERTEX_DEFORM_MACROS_SVH
`define RADIAL_LENS_VERTEX_DEFORM_MACROS_SVH

// Condition holds at every clock edge.
`define RLVD_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RLVD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RLVD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/rlvd_pkg.sv
// ----------------------------------------------------------------------------
// Radial lens vertex deform package
// Defaults, register indexes and reset values shared by the block's files.
// ----------------------------------------------------------------------------
package rlvd_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 4;
	localparam int RADIUS_WIDTH    = 10;
	localparam int INTENSITY_WIDTH = 8;
	localparam int PCT_SCALE       = 100;
	localparam int PCT_WIDTH       = 7;
	localparam int REG_INDEX_WIDTH = 2;

	localparam int CENTER_RESET    = 1600;
	localparam int RADIUS_RESET    = 100;
	localparam int INTENSITY_RESET = 100;

	typedef enum logic [REG_INDEX_WIDTH-1:0] {
		REG_CENTER_X  = 2'd0,
		REG_CENTER_Y  = 2'd1,
		REG_RADIUS    = 2'd2,
		REG_INTENSITY = 2'd3
	} rlvd_reg_t;

endpackage

FILE: rtl/core/rlvd_if.sv
// ----------------------------------------------------------------------------
// Radial lens vertex deform channels
// Valid/ready channels for vertex requests and deformed results.
// ----------------------------------------------------------------------------
interface rlvd_in_if #(
	parameter int COORD_WIDTH = rlvd_pkg::COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] elem_x;
	logic signed [COORD_WIDTH-1:0] elem_y;
	logic signed [COORD_WIDTH-1:0] tile_x;
	logic signed [COORD_WIDTH-1:0] tile_y;

	modport source (output valid, elem_x, elem_y, tile_x, tile_y, input ready);
	modport sink (input valid, elem_x, elem_y, tile_x, tile_y, output ready);
endinterface

interface rlvd_out_if #(
	parameter int COORD_WIDTH = rlvd_pkg::COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] out_x;
	logic signed [COORD_WIDTH-1:0] out_y;
	logic                          inside_lens;

	modport source (output valid, out_x, out_y, inside_lens, input ready);
	modport sink (input valid, out_x, out_y, inside_lens, output ready);
endinterface

FILE: rtl/core/radial_lens_vertex_deform.sv
// ----------------------------------------------------------------------------
// Radial lens vertex deform
// The block takes one vertex request per cycle while the result side is not
// stalled and returns one result per request, in order. The pipeline holds a
// bit-per-stage square root and a bit-per-stage restoring divider by 100
// times the scaled radius. A stalled result holds the whole pipeline in place.
// Configuration writes take effect at once; the user must make them only
// while no request is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "radial_lens_vertex_deform_macros.svh"

module radial_lens_vertex_deform #(
	parameter int COORD_WIDTH = rlvd_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = rlvd_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	rlvd_in_if.sink                                vertex,
	rlvd_out_if.source                             result,
	input  logic                                   cfg_we,
	input  logic [rlvd_pkg::REG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [COORD_WIDTH-1:0]                 cfg_data
);
	import rlvd_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int PW   = W + 1;
	localparam int DXW  = W + 2;
	localparam int RW   = RADIUS_WIDTH + FRAC_BITS;
	localparam int DW   = RW + 1;
	localparam int SQW  = 2 * DW;
	localparam int RMW  = DW + 2;
	localparam int CMW  = (DXW > RW) ? DXW : RW;
	localparam int IW   = INTENSITY_WIDTH;
	localparam int M1W  = IW + RW;
	localparam int NW   = IW + 2 * RW;
	localparam int QW   = DW;
	localparam int DENW = RW + PCT_WIDTH;
	localparam int SUMW = ((PW > QW) ? PW : QW) + 2;

	localparam logic signed [SUMW-1:0] SMAX = SUMW'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [SUMW-1:0] SMIN = -SMAX - SUMW'(1);

	typedef struct packed {
		logic signed [PW-1:0] px;
		logic signed [PW-1:0] py;
		logic [RW-1:0]        adx;
		logic [RW-1:0]        ady;
		logic                 sx;
		logic                 sy;
		logic                 near;
	} geo_t;

	typedef struct packed {
		geo_t           g;
		logic [SQW-1:0] sq;
		logic [RMW-1:0] rem;
		logic [DW-1:0]  root;
	} sqr_t;

	typedef struct packed {
		logic signed [PW-1:0] px;
		logic signed [PW-1:0] py;
		logic                 hit;
		logic                 negx;
		logic                 negy;
		logic [NW-1:0]        remx;
		logic [NW-1:0]        remy;
		logic [QW-1:0]        qx;
		logic [QW-1:0]        qy;
	} div_t;

	// Configuration registers.
	logic signed [W-1:0]         cx_q;
	logic signed [W-1:0]         cy_q;
	logic [RADIUS_WIDTH-1:0]     rad_q;
	logic signed [IW-1:0]        int_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= W'(CENTER_RESET);
			cy_q  <= W'(CENTER_RESET);
			rad_q <= RADIUS_WIDTH'(RADIUS_RESET);
			int_q <= IW'(INTENSITY_RESET);
		end else if (cfg_we) begin
			unique case (rlvd_reg_t'(cfg_index))
				REG_CENTER_X:  cx_q  <= cfg_data;
				REG_CENTER_Y:  cy_q  <= cfg_data;
				REG_RADIUS:    rad_q <= cfg_data[RADIUS_WIDTH-1:0];
				REG_INTENSITY: int_q <= cfg_data[IW-1:0];
				default: ;
			endcase
		end
	end

	logic [RW-1:0]   rs;
	logic [DENW-1:0] den;
	logic [IW-1:0]   int_mag;
	logic            int_neg;

	assign rs      = RW'(rad_q) << FRAC_BITS;
	assign den     = DENW'(rs) * DENW'(PCT_SCALE);
	assign int_neg = int_q[IW-1];
	assign int_mag = int_neg ? IW'(-int_q) : IW'(int_q);

	// Pipeline control.
	logic            adv;
	logic            v_s1, v_s2, v_s3, v_s4, v_len, v_m1, v_m2, v_out;
	logic [DW-1:0]   v_sqr;
	logic [QW-1:0]   v_div;

	assign adv          = !v_out || result.ready;
	assign vertex.ready = adv;
	assign result.valid = v_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_sqr <= '0;
			v_len <= 1'b0;
			v_m1  <= 1'b0;
			v_m2  <= 1'b0;
			v_div <= '0;
			v_out <= 1'b0;
		end else if (adv) begin
			v_s1  <= vertex.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_sqr <= {v_sqr[DW-2:0], v_s4};
			v_len <= v_sqr[DW-1];
			v_m1  <= v_len;
			v_m2  <= v_m1;
			v_div <= {v_div[QW-2:0], v_m2};
			v_out <= v_div[QW-1];
		end
	end

	// Stage 1: point and offset from the lens center.
	logic signed [PW-1:0]  px_s1, py_s1;
	logic signed [DXW-1:0] dx_s1, dy_s1;
	logic signed [PW-1:0]  px_c, py_c;

	assign px_c = PW'(vertex.elem_x) + PW'(vertex.tile_x);
	assign py_c = PW'(vertex.elem_y) + PW'(vertex.tile_y);

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= px_c;
			py_s1 <= py_c;
			dx_s1 <= DXW'(px_c) - DXW'(cx_q);
			dy_s1 <= DXW'(py_c) - DXW'(cy_q);
		end
	end

	// Stage 2: magnitudes and the square window test.
	geo_t              geo_s2;
	logic [DXW-1:0]    adx_c, ady_c;

	assign adx_c = dx_s1[DXW-1] ? DXW'(-dx_s1) : DXW'(dx_s1);
	assign ady_c = dy_s1[DXW-1] ? DXW'(-dy_s1) : DXW'(dy_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s2.px   <= px_s1;
			geo_s2.py   <= py_s1;
			geo_s2.adx  <= RW'(adx_c);
			geo_s2.ady  <= RW'(ady_c);
			geo_s2.sx   <= dx_s1[DXW-1];
			geo_s2.sy   <= dy_s1[DXW-1];
			geo_s2.near <= (CMW'(adx_c) < CMW'(rs)) && (CMW'(ady_c) < CMW'(rs));
		end
	end

	// Stages 3 and 4: squares and their sum.
	geo_t            geo_s3, geo_s4;
	logic [2*RW-1:0] sqx_s3, sqy_s3;
	logic [SQW-1:0]  sq_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s3 <= geo_s2;
			sqx_s3 <= geo_s2.adx * geo_s2.adx;
			sqy_s3 <= geo_s2.ady * geo_s2.ady;
			geo_s4 <= geo_s3;
			sq_s4  <= SQW'(sqx_s3) + SQW'(sqy_s3);
		end
	end

	// Square root, one result bit per stage.
	sqr_t sqr_in [DW];
	sqr_t sqr_sk [DW];

	assign sqr_in[0] = '{g: geo_s4, sq: sq_s4, rem: '0, root: '0};

	for (genvar i = 0; i < DW; i++) begin : g_sqr
		logic [RMW-1:0] shifted;
		logic [RMW-1:0] trial;

		if (i > 0) begin : g_link
			assign sqr_in[i] = sqr_sk[i-1];
		end

		assign shifted = {sqr_in[i].rem[RMW-3:0], sqr_in[i].sq[SQW-1-2*i -: 2]};
		assign trial   = RMW'({sqr_in[i].root, 2'b01});

		always_ff @(posedge clk) begin
			if (adv) begin
				sqr_sk[i].g  <= sqr_in[i].g;
				sqr_sk[i].sq <= sqr_in[i].sq;
				if (shifted >= trial) begin
					sqr_sk[i].rem  <= shifted - trial;
					sqr_sk[i].root <= {sqr_in[i].root[DW-2:0], 1'b1};
				end else begin
					sqr_sk[i].rem  <= shifted;
					sqr_sk[i].root <= {sqr_in[i].root[DW-2:0], 1'b0};
				end
			end
		end
	end

	// Distance left to the rim, then the two products of the numerator.
	geo_t             geo_len;
	logic             inside_len;
	logic [RW-1:0]    len_len;
	logic [DW:0]      diff_c;

	assign diff_c = (DW+1)'(rs) - (DW+1)'(sqr_sk[DW-1].root);

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_len    <= sqr_sk[DW-1].g;
			inside_len <= sqr_sk[DW-1].g.near && !diff_c[DW] && (diff_c != '0);
			len_len    <= RW'(diff_c);
		end
	end

	geo_t           geo_m1;
	logic           inside_m1;
	logic [M1W-1:0] m1_m1;

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_m1    <= geo_len;
			inside_m1 <= inside_len;
			m1_m1     <= M1W'(int_mag) * M1W'(len_len);
		end
	end

	div_t div_m2;

	always_ff @(posedge clk) begin
		if (adv) begin
			div_m2.px     <= geo_m1.px;
			div_m2.py     <= geo_m1.py;
			div_m2.hit    <= inside_m1;
			div_m2.negx   <= geo_m1.sx ^ int_neg;
			div_m2.negy   <= geo_m1.sy ^ int_neg;
			div_m2.remx   <= NW'(m1_m1) * NW'(geo_m1.adx);
			div_m2.remy   <= NW'(m1_m1) * NW'(geo_m1.ady);
			div_m2.qx     <= '0;
			div_m2.qy     <= '0;
		end
	end

	// Restoring division of both magnitudes, one quotient bit per stage.
	div_t div_in [QW];
	div_t div_sk [QW];

	assign div_in[0] = div_m2;

	for (genvar i = 0; i < QW; i++) begin : g_div
		localparam int K = QW - 1 - i;
		logic [NW-1:0] dsh;

		if (i > 0) begin : g_link
			assign div_in[i] = div_sk[i-1];
		end

		assign dsh = NW'(den) << K;

		always_ff @(posedge clk) begin
			if (adv) begin
				div_sk[i].px     <= div_in[i].px;
				div_sk[i].py     <= div_in[i].py;
				div_sk[i].hit    <= div_in[i].hit;
				div_sk[i].negx   <= div_in[i].negx;
				div_sk[i].negy   <= div_in[i].negy;
				div_sk[i].qx     <= div_in[i].qx | ((div_in[i].remx >= dsh) ? QW'(1) << K : '0);
				div_sk[i].qy     <= div_in[i].qy | ((div_in[i].remy >= dsh) ? QW'(1) << K : '0);
				div_sk[i].remx   <= (div_in[i].remx >= dsh) ? div_in[i].remx - dsh
					: div_in[i].remx;
				div_sk[i].remy   <= (div_in[i].remy >= dsh) ? div_in[i].remy - dsh
					: div_in[i].remy;
			end
		end
	end

	// Output stage: apply the move and saturate.
	div_t                  dl;
	logic signed [SUMW-1:0] movx_c, movy_c, sumx_c, sumy_c;
	logic signed [W-1:0]    ox_out, oy_out;
	logic                   inside_out;

	assign dl     = div_sk[QW-1];
	assign movx_c = !dl.hit ? '0 : dl.negx ? -SUMW'(dl.qx) : SUMW'(dl.qx);
	assign movy_c = !dl.hit ? '0 : dl.negy ? -SUMW'(dl.qy) : SUMW'(dl.qy);
	assign sumx_c = SUMW'(dl.px) + movx_c;
	assign sumy_c = SUMW'(dl.py) + movy_c;

	always_ff @(posedge clk) begin
		if (adv) begin
			ox_out     <= (sumx_c > SMAX) ? W'(SMAX) : (sumx_c < SMIN) ? W'(SMIN) : W'(sumx_c);
			oy_out     <= (sumy_c > SMAX) ? W'(SMAX) : (sumy_c < SMIN) ? W'(SMIN) : W'(sumy_c);
			inside_out <= dl.hit;
		end
	end

	assign result.out_x       = ox_out;
	assign result.out_y       = oy_out;
	assign result.inside_lens = inside_out;

	logic [SQW+1:0] rt_w, sq_w;
	logic           sqrt_ok;

	assign rt_w    = (SQW+2)'(sqr_sk[DW-1].root);
	assign sq_w    = (SQW+2)'(sqr_sk[DW-1].sq);
	assign sqrt_ok = (rt_w * rt_w <= sq_w)
		&& ((rt_w + (SQW+2)'(1)) * (rt_w + (SQW+2)'(1)) > sq_w);

	// A waiting result stays until it is taken.
	`RLVD_ASSERT_NXT(a_hold_result, v_out && !adv, v_out, "result dropped while stalled")
	// The square root is the floor of the true root.
	`RLVD_ASSERT_IMP(a_sqrt_floor, v_sqr[DW-1] && sqr_sk[DW-1].g.near, sqrt_ok, "bad root")
	// The divider leaves a remainder below the divisor.
	`RLVD_ASSERT_IMP(a_div_rem, v_div[QW-1] && dl.hit, (dl.remx < NW'(den)) && (dl.remy < NW'(den)), "divider remainder too large")

endmodule
